// ===== rtl/rgbhsi_pkg.sv =====
// Shared types, widths and constants for the RGB to HSI converter.
package rgbhsi_pkg;

  localparam int HueIterations = 16;
  localparam int CordicStages  = (HueIterations > 24) ? 24 : HueIterations;
  localparam int Latency       = CordicStages + 3;

  localparam int XW  = 29;
  localparam int AW  = 35;
  localparam int NW  = 19;
  localparam int DW  = 11;
  localparam int QW  = 8;

  localparam logic [16:0] Sqrt3Q16 = 17'd113512;
  localparam logic [13:0] RecipSix = 14'd10923;
  localparam logic signed [AW-1:0] QuarterTurn = AW'(64'sd1073741824);
  localparam logic signed [AW-1:0] HalfTurn    = AW'(64'sd2147483648);

  localparam logic [29:0] AtanTurns [24] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef struct packed {
    logic       gray;
    logic       axis;
    logic       xpos;
    logic       bgtg;
    logic [7:0] intensity;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] ang;
    logic [NW-1:0]        rem;
    logic [DW-1:0]        den;
    logic [QW-1:0]        quo;
    side_t                side;
  } work_t;

endpackage

// ===== rtl/rgbhsi_front.sv =====
// Input stages: channel analysis, vector setup, saturation operands and intensity.
module rgbhsi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                valid_o,
  output rgbhsi_pkg::work_t   work_o
);

  logic              v1_q;
  logic [9:0]        sum_q;
  logic [7:0]        mn_q;
  logic [7:0]        d_q;
  logic signed [10:0] xs_q;
  logic              gray_q, axis_q, bgtg_q;
  logic              v2_q;
  rgbhsi_pkg::work_t work_q;

  logic [9:0]         sum_d;
  logic [7:0]         mn_d;
  logic signed [10:0] xs_d;

  always_comb begin
    sum_d = {2'b0, red_i} + {2'b0, green_i} + {2'b0, blue_i};
    mn_d  = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn_d) mn_d = blue_i;
    xs_d  = $signed({2'b0, red_i, 1'b0}) - $signed({3'b0, green_i})
          - $signed({3'b0, blue_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    mn_q   <= mn_d;
    xs_q   <= xs_d;
    d_q    <= (green_i > blue_i) ? (green_i - blue_i) : (blue_i - green_i);
    gray_q <= (red_i == green_i) && (green_i == blue_i);
    axis_q <= (green_i == blue_i);
    bgtg_q <= (blue_i > green_i);
  end

  logic signed [rgbhsi_pkg::XW-1:0] x0, ymul_s;
  logic [24:0]                      ymul;
  logic [9:0]                       diff;
  logic [18:0]                      num_sat;
  logic [10:0]                      num_int;
  logic [24:0]                      prod_int;
  rgbhsi_pkg::work_t                work_d;

  always_comb begin
    x0       = {{(rgbhsi_pkg::XW-27){xs_q[10]}}, xs_q, 16'b0};
    ymul     = d_q * rgbhsi_pkg::Sqrt3Q16;
    ymul_s   = $signed({{(rgbhsi_pkg::XW-25){1'b0}}, ymul});
    diff     = sum_q - 10'(3 * mn_q);
    num_sat  = {9'b0, diff} * 19'd510 + {9'b0, sum_q};
    num_int  = {sum_q, 1'b0} + 11'd3;
    prod_int = num_int * rgbhsi_pkg::RecipSix;
    work_d   = '0;
    if (x0 < 0) begin
      work_d.x   = ymul_s;
      work_d.y   = -x0;
      work_d.ang = rgbhsi_pkg::QuarterTurn;
    end else begin
      work_d.x   = x0;
      work_d.y   = ymul_s;
      work_d.ang = '0;
    end
    work_d.rem            = num_sat;
    work_d.den            = {sum_q, 1'b0};
    work_d.quo            = '0;
    work_d.side.gray      = gray_q;
    work_d.side.axis      = axis_q;
    work_d.side.xpos      = (xs_q > 0);
    work_d.side.bgtg      = bgtg_q;
    work_d.side.intensity = prod_int[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign valid_o = v2_q;
  assign work_o  = work_q;

endmodule

// ===== rtl/rgbhsi_cordic.sv =====
// Vectoring CORDIC stages, one rotation per stage, with a restoring divider alongside.
module rgbhsi_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rgbhsi_pkg::work_t work_i,
  output logic              valid_o,
  output rgbhsi_pkg::work_t work_o
);

  localparam int NS = rgbhsi_pkg::CordicStages;

  rgbhsi_pkg::work_t st_q [NS];
  logic              sv_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam int Sh = (i < rgbhsi_pkg::QW) ? (rgbhsi_pkg::QW - 1 - i) : 0;
    rgbhsi_pkg::work_t cur, nxt;
    logic              cur_v;
    logic [rgbhsi_pkg::NW-1:0] dsh;

    if (i == 0) begin : g_first
      assign cur   = work_i;
      assign cur_v = valid_i;
    end else begin : g_next
      assign cur   = st_q[i-1];
      assign cur_v = sv_q[i-1];
    end

    always_comb begin
      nxt = cur;
      dsh = {{(rgbhsi_pkg::NW-rgbhsi_pkg::DW){1'b0}}, cur.den} << Sh;
      if (cur.y >= 0) begin
        nxt.x   = cur.x + (cur.y >>> i);
        nxt.y   = cur.y - (cur.x >>> i);
        nxt.ang = cur.ang + $signed({5'b0, rgbhsi_pkg::AtanTurns[i]});
      end else begin
        nxt.x   = cur.x - (cur.y >>> i);
        nxt.y   = cur.y + (cur.x >>> i);
        nxt.ang = cur.ang - $signed({5'b0, rgbhsi_pkg::AtanTurns[i]});
      end
      if (i < rgbhsi_pkg::QW) begin
        if (cur.rem >= dsh) begin
          nxt.rem     = cur.rem - dsh;
          nxt.quo[Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i] <= 1'b0;
      end else begin
        sv_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[i] <= nxt;
    end
  end

  assign valid_o = sv_q[NS-1];
  assign work_o  = st_q[NS-1];

endmodule

// ===== rtl/rgbhsi_back.sv =====
// Output stage: angle clamp, reflection, hue scaling and result register.
module rgbhsi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rgbhsi_pkg::work_t work_i,
  output logic              valid_o,
  output logic [7:0]        hue_o,
  output logic [7:0]        saturation_o,
  output logic [7:0]        intensity_o
);

  logic signed [rgbhsi_pkg::AW-1:0] angc;
  logic [32:0] turn;
  logic [40:0] prod;
  logic [8:0]  h;
  logic [7:0]  hue_d, sat_d;
  logic        v_q;
  logic [7:0]  hue_q, sat_q, int_q;

  always_comb begin
    angc = work_i.ang;
    if (angc < 0) angc = '0;
    if (angc > rgbhsi_pkg::HalfTurn) angc = rgbhsi_pkg::HalfTurn;
    if (work_i.side.axis) angc = work_i.side.xpos ? '0 : rgbhsi_pkg::HalfTurn;
    turn = 33'(angc);
    if (work_i.side.bgtg) turn = 33'h1_0000_0000 - turn;
    prod  = {turn, 8'b0} - {8'b0, turn} + 41'h0_8000_0000;
    h     = prod[40:32];
    hue_d = (h > 9'd255) ? 8'd255 : h[7:0];
    sat_d = work_i.quo;
    if (work_i.side.gray) begin
      hue_d = '0;
      sat_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q <= hue_d;
    sat_q <= sat_d;
    int_q <= work_i.side.intensity;
  end

  assign valid_o      = v_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign intensity_o  = int_q;

endmodule

// ===== rtl/rgb_to_hsi_converter.sv =====
// Top level of the RGB to HSI converter.
// From start_i to valid_o each input passes the front stages, the CORDIC stages and the output register.
// Throughput: one transaction per cycle; busy_o stays low.
// The receiver cannot stall; each result shows for one cycle with valid_o.
// Reset clears all valid bits asynchronously; data registers are not reset.
module rgb_to_hsi_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       valid_o,
  output logic [7:0] hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] intensity_o
);

  logic              acc;
  logic              fv, cv;
  rgbhsi_pkg::work_t fw, cw;

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  rgbhsi_front u_front (
    .clk_i, .rst_ni, .valid_i(acc), .red_i, .green_i, .blue_i,
    .valid_o(fv), .work_o(fw)
  );

  rgbhsi_cordic u_cordic (
    .clk_i, .rst_ni, .valid_i(fv), .work_i(fw), .valid_o(cv), .work_o(cw)
  );

  rgbhsi_back u_back (
    .clk_i, .rst_ni, .valid_i(cv), .work_i(cw),
    .valid_o, .hue_o, .saturation_o, .intensity_o
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##(rgbhsi_pkg::Latency) valid_o) else $error("result missing");
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |-> ##(rgbhsi_pkg::Latency) !valid_o) else $error("result invented");
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && red_i == green_i && green_i == blue_i) |-> ##(rgbhsi_pkg::Latency)
    (hue_o == 8'd0 && saturation_o == 8'd0)) else $error("gray pixel not zeroed");
`endif

endmodule
